// File: rtl/core/fdfnv_pkg.sv
// ----------------------------------------------------------------------------
// fdfnv_pkg
// Types and constants for the length-prefixed frame deframer with FNV-1a check.
// ----------------------------------------------------------------------------
package fdfnv_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [31:0] FRAME_MAGIC = 32'h4D55_4F4E;
    localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME   = 32'd16777619;

    localparam int unsigned HEADER_BYTES  = 12;
    localparam int unsigned TRAILER_BYTES = 4;

    localparam logic [15:0] VERSION_RESET = 16'd1;
    localparam logic [23:0] MAX_LEN_RESET = 24'd1048576;

    // register indexes on the APB port (word address)
    localparam logic REG_VERSION = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    typedef logic [2:0] t_err;
    localparam t_err ERR_NONE     = 3'd0;
    localparam t_err ERR_MAGIC    = 3'd1;
    localparam t_err ERR_VERSION  = 3'd2;
    localparam t_err ERR_TOO_LONG = 3'd3;
    localparam t_err ERR_CHECKSUM = 3'd4;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } t_phase;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] frame_key;
        logic [23:0] payload_length;
        logic        frame_end;
        logic        frame_ok;
        t_err        err_code;
        logic        closed;
    } t_result;

endpackage

// File: rtl/core/frame_deframer_fnv_check.sv
// ----------------------------------------------------------------------------
// frame_deframer_fnv_check
// Byte-wide deframer: header parse, payload pass-through with FNV-1a-32 hash,
// trailer compare, sticky error state.
// ----------------------------------------------------------------------------
// Output: each accepted byte's result word is formed combinationally and registered.
// Throughput: 1 byte per cycle while o_in_stall is low; the hash multiply and counter
// update sit in one stage between the accepted byte and the output register.
// A two-entry output (register plus skid) takes one more word under output stall.
// Reset (synchronous, active low): header phase, counters and shifts cleared,
// hash at offset basis, error cleared, registers at their defaults.
module frame_deframer_fnv_check #(
    parameter int unsigned LENGTH_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_rx_byte,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_payload_valid,
    output logic [7:0]                     o_payload_byte,
    output logic [15:0]                    o_frame_key,
    output logic [23:0]                    o_payload_length,
    output logic                           o_frame_end,
    output logic                           o_frame_ok,
    output logic [2:0]                     o_err_code,
    output logic                           o_closed,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fdfnv_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic [31:0] LenMask = 32'((64'd1 << LENGTH_BITS) - 64'd1);

    // ---------------- configuration ----------------
    logic [15:0] r_protocol_version;
    logic [23:0] r_max_payload_size;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol_version <= fdfnv_pkg::VERSION_RESET;
            r_max_payload_size <= fdfnv_pkg::MAX_LEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                fdfnv_pkg::REG_VERSION: r_protocol_version <= pwdata[15:0];
                fdfnv_pkg::REG_MAX_LEN: r_max_payload_size <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fdfnv_pkg::REG_VERSION: prdata = {16'd0, r_protocol_version};
            fdfnv_pkg::REG_MAX_LEN: prdata = {8'd0, r_max_payload_size};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------- parser state ----------------
    fdfnv_pkg::t_phase        r_phase, n_phase;
    logic [LENGTH_BITS-1:0]   r_byte_cnt, n_byte_cnt;
    logic [31:0]              r_magic, n_magic;
    logic [15:0]              r_version, n_version;
    logic [15:0]              r_key, n_key;
    logic [31:0]              r_length, n_length;
    logic [31:0]              r_hash, n_hash;
    logic [31:0]              r_trailer, n_trailer;
    fdfnv_pkg::t_err          r_sticky, n_sticky;

    fdfnv_pkg::t_result       result;
    fdfnv_pkg::t_result       r_out, r_skid;
    logic                     r_out_valid, r_skid_valid;
    logic                     in_accept;
    logic                     out_take;

    logic [31:0]              limit;
    logic [31:0]              len_masked;
    logic [31:0]              hash_mix;
    logic [LENGTH_BITS-1:0]   cnt_inc;
    logic                     fend, fok;

    assign in_accept = i_in_valid & ~r_skid_valid;
    assign out_take  = r_out_valid & ~i_out_stall;

    assign limit    = ({8'd0, r_max_payload_size} < LenMask) ?
                      {8'd0, r_max_payload_size} : LenMask;
    assign hash_mix = 32'((r_hash ^ {24'd0, i_rx_byte}) * fdfnv_pkg::FNV_PRIME);
    assign cnt_inc  = r_byte_cnt + LENGTH_BITS'(1);

    always_comb begin
        n_phase    = r_phase;
        n_byte_cnt = r_byte_cnt;
        n_magic    = r_magic;
        n_version  = r_version;
        n_key      = r_key;
        n_length   = r_length;
        n_hash     = r_hash;
        n_trailer  = r_trailer;
        n_sticky   = r_sticky;
        fend       = 1'b0;
        fok        = 1'b0;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;

        if (in_accept && r_sticky == fdfnv_pkg::ERR_NONE) begin
            case (r_phase)
                fdfnv_pkg::PH_HEADER: begin
                    if (r_byte_cnt < LENGTH_BITS'(4)) begin
                        n_magic = {r_magic[23:0], i_rx_byte};
                    end else if (r_byte_cnt < LENGTH_BITS'(6)) begin
                        n_version = {r_version[7:0], i_rx_byte};
                    end else if (r_byte_cnt < LENGTH_BITS'(8)) begin
                        n_key = {r_key[7:0], i_rx_byte};
                    end else begin
                        n_length = {r_length[23:0], i_rx_byte};
                    end
                    if (r_byte_cnt >= LENGTH_BITS'(fdfnv_pkg::HEADER_BYTES - 1)) begin
                        n_byte_cnt = '0;
                        n_hash     = fdfnv_pkg::FNV_BASIS;
                        n_trailer  = 32'd0;
                        // checks in priority order: magic, version, length
                        if (r_magic != fdfnv_pkg::FRAME_MAGIC) begin
                            n_sticky = fdfnv_pkg::ERR_MAGIC;
                        end else if (r_version != r_protocol_version) begin
                            n_sticky = fdfnv_pkg::ERR_VERSION;
                        end else if (n_length > limit) begin
                            n_sticky = fdfnv_pkg::ERR_TOO_LONG;
                        end else if (n_length == 32'd0) begin
                            n_phase = fdfnv_pkg::PH_TRAILER;
                        end else begin
                            n_phase = fdfnv_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        n_byte_cnt = cnt_inc;
                    end
                end
                fdfnv_pkg::PH_PAYLOAD: begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = i_rx_byte;
                    n_hash     = hash_mix;
                    n_byte_cnt = cnt_inc;
                    if (cnt_inc >= r_length[LENGTH_BITS-1:0]) begin
                        n_byte_cnt = '0;
                        n_phase    = fdfnv_pkg::PH_TRAILER;
                    end
                end
                fdfnv_pkg::PH_TRAILER: begin
                    n_trailer = {r_trailer[23:0], i_rx_byte};
                    if (r_byte_cnt >= LENGTH_BITS'(fdfnv_pkg::TRAILER_BYTES - 1)) begin
                        fend = 1'b1;
                        fok  = (n_trailer == r_hash);
                        if (!fok) begin
                            n_sticky = fdfnv_pkg::ERR_CHECKSUM;
                        end
                        n_byte_cnt = '0;
                        n_hash     = fdfnv_pkg::FNV_BASIS;
                        n_phase    = fdfnv_pkg::PH_HEADER;
                    end else begin
                        n_byte_cnt = cnt_inc;
                    end
                end
                default: begin
                    n_phase = fdfnv_pkg::PH_HEADER;
                end
            endcase
        end

        len_masked            = n_length & LenMask;
        result.frame_key      = n_key;
        result.payload_length = len_masked[23:0];
        result.frame_end      = fend;
        result.frame_ok       = fok;
        result.err_code       = n_sticky;
        result.closed         = (n_sticky != fdfnv_pkg::ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= fdfnv_pkg::PH_HEADER;
            r_byte_cnt <= '0;
            r_magic    <= 32'd0;
            r_version  <= 16'd0;
            r_key      <= 16'd0;
            r_length   <= 32'd0;
            r_hash     <= fdfnv_pkg::FNV_BASIS;
            r_trailer  <= 32'd0;
            r_sticky   <= fdfnv_pkg::ERR_NONE;
        end else begin
            r_phase    <= n_phase;
            r_byte_cnt <= n_byte_cnt;
            r_magic    <= n_magic;
            r_version  <= n_version;
            r_key      <= n_key;
            r_length   <= n_length;
            r_hash     <= n_hash;
            r_trailer  <= n_trailer;
            r_sticky   <= n_sticky;
        end
    end

    // ---------------- output register + skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_accept) begin
            r_skid <= result;
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_frame_key      = r_out.frame_key;
    assign o_payload_length = r_out.payload_length;
    assign o_frame_end      = r_out.frame_end;
    assign o_frame_ok       = r_out.frame_ok;
    assign o_err_code       = r_out.err_code;
    assign o_closed         = r_out.closed;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sticky != fdfnv_pkg::ERR_NONE) |=> $stable(r_sticky))
        else $error("sticky error changed after close");

    a_closed_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_closed) |-> (!o_payload_valid && !o_frame_ok))
        else $error("payload or good frame reported while closed");

    a_ok_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_ok) |-> (o_frame_end && o_err_code == fdfnv_pkg::ERR_NONE))
        else $error("frame_ok without frame_end or with error");

    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == fdfnv_pkg::PH_PAYLOAD && r_sticky == fdfnv_pkg::ERR_NONE)
        |-> (r_length != 32'd0))
        else $error("payload phase entered with zero length");

endmodule
